// ===== rtl/core/mwis_pkg.sv =====
`default_nettype none
package mwis_pkg;

    localparam int HEIGHT_W = 13;
    localparam int WEIGHT_W = 30;
    localparam int SCORE_W  = 48;
    localparam int EPOCH_W  = 8;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [WEIGHT_W-1:0] weight;
        logic                last_item;
    } t_in_item;

    typedef struct packed {
        logic [SCORE_W-1:0] item_score;
        logic [SCORE_W-1:0] best_score;
        logic               sequence_end;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic q_step;
        logic score;
        logic u_step;
        logic finish;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic q_done;
        logic u_done;
        logic clr_done;
        logic out_busy;
        logic wrap;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/core/mwis_ctrl.sv =====
`default_nettype none
module mwis_ctrl (
    input  var logic          i_clk,
    input  var logic          i_rst_n,
    input  var logic          i_in_valid,
    output logic              o_in_ready,
    input  var mwis_pkg::t_sts i_sts,
    output mwis_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_QUERY  = 6'b000100,
        S_SCORE  = 6'b001000,
        S_UPDATE = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_QUERY;
                end
            end
            S_QUERY: begin
                if (i_sts.q_done) begin
                    n_state = S_SCORE;
                end else begin
                    o_cmd.q_step = 1'b1;
                end
            end
            S_SCORE: begin
                o_cmd.score = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_sts.u_done) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.u_step = 1'b1;
                end
            end
            S_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = i_sts.wrap ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mwis_dpath.sv =====
`default_nettype none
module mwis_dpath #(
    parameter int MAX_HEIGHT = 4096,
    parameter int SUM_WIDTH  = 48
) (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var mwis_pkg::t_cmd      i_cmd,
    input  var mwis_pkg::t_in_item  i_in,
    input  var logic                i_out_ready,
    output mwis_pkg::t_sts          o_sts,
    output logic                    o_out_valid,
    output mwis_pkg::t_out_item     o_out
);

    localparam int AW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int IW    = AW + 2;
    localparam int CW    = (IW > mwis_pkg::HEIGHT_W) ? IW : mwis_pkg::HEIGHT_W;
    localparam int EW    = mwis_pkg::EPOCH_W;
    localparam int MEM_W = EW + SUM_WIDTH;

    logic [MEM_W-1:0]     r_mem [MAX_HEIGHT];
    logic [MEM_W-1:0]     r_rd_q;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_rd_vld;
    logic                 r_rd_upd;
    logic [IW-1:0]        r_height;
    logic [mwis_pkg::WEIGHT_W-1:0] r_weight;
    logic                 r_last;
    logic [SUM_WIDTH-1:0] r_acc;
    logic [SUM_WIDTH-1:0] r_best;
    logic [EW-1:0]        r_epoch;
    logic [AW-1:0]        r_clr;
    logic                 r_out_vld;
    mwis_pkg::t_out_item  r_out;

    logic [CW-1:0]        raw_h;
    logic [IW-1:0]        clamp_h;
    logic [IW-1:0]        low_bit;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wb_addr;
    logic [SUM_WIDTH-1:0] rd_sum;
    logic [SUM_WIDTH:0]   sum_ext;
    logic [SUM_WIDTH-1:0] score_sat;
    logic [SUM_WIDTH-1:0] new_best;
    logic [63:0]          score_64;
    logic [63:0]          best_64;
    logic                 wb_en;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [MEM_W-1:0]     mem_wdata;

    always_comb begin
        raw_h = CW'(i_in.height);
        if (raw_h == '0) begin
            raw_h = CW'(1);
        end else if (raw_h > CW'(MAX_HEIGHT)) begin
            raw_h = CW'(MAX_HEIGHT);
        end
        clamp_h = raw_h[IW-1:0];
    end

    assign low_bit = r_idx & (~r_idx + IW'(1));
    assign rd_addr = AW'(r_idx - IW'(1));
    assign wb_addr = AW'(r_rd_idx - IW'(1));
    assign rd_sum  = (r_rd_q[MEM_W-1 -: EW] == r_epoch) ? r_rd_q[SUM_WIDTH-1:0] : '0;

    assign sum_ext   = {1'b0, r_acc} + (SUM_WIDTH+1)'(r_weight);
    assign score_sat = sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];
    assign new_best  = (r_acc > r_best) ? r_acc : r_best;
    assign score_64  = 64'(r_acc);
    assign best_64   = 64'(new_best);

    assign wb_en     = r_rd_vld && r_rd_upd && (rd_sum < r_acc);
    assign mem_we    = wb_en || i_cmd.clr_step;
    assign mem_waddr = i_cmd.clr_step ? r_clr : wb_addr;
    assign mem_wdata = i_cmd.clr_step ? '0 : {r_epoch, r_acc};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_height <= clamp_h;
            r_weight <= i_in.weight;
            r_last   <= i_in.last_item;
        end
        if (i_cmd.load) begin
            r_idx <= clamp_h;
        end else if (i_cmd.q_step) begin
            r_idx <= r_idx - low_bit;
        end else if (i_cmd.score) begin
            r_idx <= r_height;
        end else if (i_cmd.u_step) begin
            r_idx <= r_idx + low_bit;
        end
        if (i_cmd.u_step) begin
            r_rd_idx <= r_idx;
        end
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (i_cmd.score) begin
            r_acc <= score_sat;
        end else if (r_rd_vld && !r_rd_upd && (rd_sum > r_acc)) begin
            r_acc <= rd_sum;
        end
        if (i_cmd.finish) begin
            r_out.item_score   <= score_64[mwis_pkg::SCORE_W-1:0];
            r_out.best_score   <= best_64[mwis_pkg::SCORE_W-1:0];
            r_out.sequence_end <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_rd_upd  <= 1'b0;
            r_best    <= '0;
            r_epoch   <= EW'(1);
            r_clr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.q_step || i_cmd.u_step;
            r_rd_upd <= i_cmd.u_step;
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_best <= '0;
                    if (o_sts.wrap) begin
                        r_epoch <= EW'(1);
                        r_clr   <= '0;
                    end else begin
                        r_epoch <= r_epoch + EW'(1);
                    end
                end else begin
                    r_best <= new_best;
                end
            end
        end
    end

    always_comb begin
        o_sts.q_done   = (r_idx == '0);
        o_sts.u_done   = (r_idx > IW'(MAX_HEIGHT));
        o_sts.clr_done = (r_clr == AW'(MAX_HEIGHT - 1));
        o_sts.out_busy = r_out_vld && !i_out_ready;
        o_sts.wrap     = r_last && (r_epoch == '1);
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// ===== rtl/core/max_weight_increasing_subsequence.sv =====
// Flow: an accepted item runs popcount(h) Fenwick query steps, a score step, then Fenwick raise
// steps and a finish that loads the result; each Fenwick step makes one memory read.
// Flow control: one item at a time; the next item is taken once the result has loaded and any
// due clearing pass is done; a waiting result holds the finish.
// Reset: synchronous, active low; a clearing pass over all MAX_HEIGHT table entries follows
// reset and runs again after every 255th sequence, with no item taken meanwhile.
`default_nettype none
module max_weight_increasing_subsequence #(
    parameter int MAX_HEIGHT = 4096,
    parameter int SUM_WIDTH  = 48
) (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var logic                i_in_valid,
    output logic                    o_in_ready,
    input  var mwis_pkg::t_in_item  i_in,
    output logic                    o_out_valid,
    input  var logic                i_out_ready,
    output mwis_pkg::t_out_item     o_out
);

    mwis_pkg::t_cmd w_cmd;
    mwis_pkg::t_sts w_sts;

    mwis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mwis_dpath #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .SUM_WIDTH  (SUM_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command");

    a_hold_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item taken while previous item in flight");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("item taken before clearing pass");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.finish))
        else $error("result shown without finish");

endmodule
`default_nettype wire
